>>> rtl/core/bbpt_pkg.sv
// Shared types and codes for the buzzer beep pattern timer.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package bbpt_pkg;

    // Command codes carried in the mode field of an input item.
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_KEY   = 3'd1,
        MODE_TIMED = 3'd2,
        MODE_MULTI = 3'd3,
        MODE_STOP  = 3'd4
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_KEY_LEN  = 2'd1,
        CFG_LOCKOUT  = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Register values after reset.
    localparam logic [15:0] KEY_LEN_RESET = 16'd50;
    localparam logic [7:0]  LOCKOUT_RESET = 8'd100;

endpackage

>>> rtl/core/bbpt_serial_div.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Standalone; instantiated by buzzer_beep_pattern_timer.
`timescale 1ns / 1ps

module bbpt_serial_div #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] dividend,
    input  logic [COUNT_BITS:0]   divisor,
    output logic                  done,
    output logic [COUNT_BITS-1:0] quotient,
    output logic [COUNT_BITS:0]   remainder
);

    localparam int DW = COUNT_BITS + 1;
    localparam int CNT_W = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COUNT_BITS - 1);

    logic [DW-1:0]         rem_reg;
    logic [DW-1:0]         rem_next;
    logic [COUNT_BITS-1:0] quo_reg;
    logic [COUNT_BITS-1:0] quo_next;
    logic [DW-1:0]         div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DW:0]           trial;
    logic [DW:0]           diff;
    logic                  fits;

    // One restoring step: bring in the next dividend bit and try to subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[COUNT_BITS-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {quo_reg[COUNT_BITS-2:0], fits};
    end

    // Step counter and handshake with the caller.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/buzzer_beep_pattern_timer.sv
// Buzzer beep pattern timer: one result item for every input item.
// Each accepted item passes through the push state, which loads the result once the
// output slot is free; a multi beep command or a tick during an active multi beep first
// runs the bit-serial divider that finds the toggle period or the remainder.
// A new item is accepted only once the result of the last one has been loaded.
// Reset (rst_n low, asynchronous) clears the beep state and loads the register defaults.
// Depends on bbpt_pkg and bbpt_serial_div.
`timescale 1ns / 1ps

module buzzer_beep_pattern_timer
    import bbpt_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int QUIET_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                mode,
    input  logic [15:0]               duration,
    input  logic [7:0]                beep_count,
    input  logic                      key_is_start,
    input  logic                      system_idle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      buzzer_level,
    output logic                      sounding,
    output logic                      multi_active,
    output logic                      lockout_active
);

    localparam int DW = COUNT_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    // Configuration registers.
    logic        enable_reg;
    logic [15:0] key_len_reg;
    logic [7:0]  lockout_reg;

    // Beep state.
    state_t                state_reg;
    state_t                state_next;
    logic [COUNT_BITS-1:0] remaining_reg;
    logic [COUNT_BITS-1:0] remaining_next;
    logic                  active_reg;
    logic                  active_next;
    logic                  multi_reg;
    logic                  multi_next;
    logic [COUNT_BITS-1:0] period_reg;
    logic [COUNT_BITS-1:0] period_next;
    logic [QUIET_BITS-1:0] quiet_reg;
    logic [QUIET_BITS-1:0] quiet_next;
    logic                  pin_reg;
    logic                  pin_next;
    logic                  div_period_reg;
    logic                  div_period_next;

    // Output slot.
    logic out_valid_reg;
    logic out_valid_next;
    logic buzzer_level_reg;
    logic sounding_reg;
    logic multi_active_reg;
    logic lockout_active_reg;
    logic out_load;

    // Divider interface.
    logic                  div_start;
    logic [COUNT_BITS-1:0] div_dividend;
    logic [DW-1:0]         div_divisor;
    logic                  div_done;
    logic [COUNT_BITS-1:0] div_quotient;
    logic [DW-1:0]         div_remainder;

    // Item fields at internal widths.
    logic [COUNT_BITS-1:0] dur_cnt;
    logic [COUNT_BITS-1:0] key_len_cnt;
    logic [QUIET_BITS-1:0] lockout_q;
    logic [QUIET_BITS-1:0] quiet_base;
    logic [7:0]            count_nz;
    logic                  beep_ended;

    assign dur_cnt     = COUNT_BITS'(duration);
    assign key_len_cnt = COUNT_BITS'(key_len_reg);
    assign lockout_q   = QUIET_BITS'(lockout_reg);
    assign count_nz    = (beep_count == 8'd0) ? 8'd1 : beep_count;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            key_len_reg <= KEY_LEN_RESET;
            lockout_reg <= LOCKOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_KEY_LEN: key_len_reg <= cfg_data[15:0];
                CFG_LOCKOUT: lockout_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    // Item decode, divider sequencing and result hand-off.
    always_comb
    begin
        state_next      = state_reg;
        remaining_next  = remaining_reg;
        active_next     = active_reg;
        multi_next      = multi_reg;
        period_next     = period_reg;
        quiet_next      = quiet_reg;
        pin_next        = pin_reg;
        div_period_next = div_period_reg;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;
        beep_ended      = 1'b0;
        quiet_base      = quiet_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg & ~out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PUSH;
                    case (mode)
                        MODE_TICK:
                        begin
                            if (active_reg)
                            begin
                                if (remaining_reg != '0)
                                begin
                                    remaining_next = remaining_reg - 1'b1;
                                    if (multi_reg)
                                    begin
                                        div_start       = 1'b1;
                                        div_dividend    = remaining_reg - 1'b1;
                                        div_divisor     = DW'(period_reg);
                                        div_period_next = 1'b0;
                                        state_next      = ST_DIV;
                                    end
                                end
                                else
                                begin
                                    beep_ended  = 1'b1;
                                    pin_next    = 1'b0;
                                    active_next = 1'b0;
                                    multi_next  = 1'b0;
                                end
                            end
                            // The quiet interval loaded at beep end counts on this tick too.
                            quiet_base = beep_ended ? lockout_q : quiet_reg;
                            quiet_next = (quiet_base != '0) ? quiet_base - 1'b1 : quiet_base;
                        end
                        MODE_KEY:
                        begin
                            if (quiet_reg == '0)
                            begin
                                multi_next = 1'b0;
                                if (!active_reg && enable_reg)
                                begin
                                    if (key_is_start && system_idle)
                                    begin
                                        remaining_next = '0;
                                    end
                                    else
                                    begin
                                        active_next    = 1'b1;
                                        remaining_next = key_len_cnt;
                                        pin_next       = 1'b1;
                                    end
                                end
                            end
                        end
                        MODE_TIMED:
                        begin
                            // A leftover count is taken off the new duration.
                            if (!active_reg && enable_reg)
                            begin
                                active_next    = 1'b1;
                                pin_next       = 1'b1;
                                remaining_next = dur_cnt - remaining_reg;
                            end
                        end
                        MODE_MULTI:
                        begin
                            if (!active_reg && enable_reg)
                            begin
                                multi_next      = 1'b1;
                                active_next     = 1'b1;
                                pin_next        = 1'b1;
                                remaining_next  = dur_cnt;
                                div_start       = 1'b1;
                                div_dividend    = dur_cnt;
                                div_divisor     = DW'({count_nz, 1'b0});
                                div_period_next = 1'b1;
                                state_next      = ST_DIV;
                            end
                        end
                        MODE_STOP:
                        begin
                            pin_next    = 1'b0;
                            active_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PUSH;
                    if (div_period_reg)
                    begin
                        period_next = (div_quotient == '0) ? COUNT_BITS'(1) : div_quotient;
                    end
                    else if (div_remainder == '0)
                    begin
                        pin_next = ~pin_reg;
                    end
                end
            end
            ST_PUSH:
            begin
                // Load the result once the output slot is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            remaining_reg  <= '0;
            active_reg     <= 1'b0;
            multi_reg      <= 1'b0;
            period_reg     <= COUNT_BITS'(1);
            quiet_reg      <= '0;
            pin_reg        <= 1'b0;
            div_period_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            remaining_reg  <= remaining_next;
            active_reg     <= active_next;
            multi_reg      <= multi_next;
            period_reg     <= period_next;
            quiet_reg      <= quiet_next;
            pin_reg        <= pin_next;
            div_period_reg <= div_period_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload, captured from the state after the item.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            buzzer_level_reg   <= pin_reg;
            sounding_reg       <= active_reg;
            multi_active_reg   <= active_reg & multi_reg;
            lockout_active_reg <= (quiet_reg != '0);
        end
    end

    bbpt_serial_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign buzzer_level   = buzzer_level_reg;
    assign sounding       = sounding_reg;
    assign multi_active   = multi_active_reg;
    assign lockout_active = lockout_active_reg;

endmodule
